@@ rtl/core/iol_pkg.sv @@
// Shared types and constants for the indexed ordered list unit.
package iol_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int PORT_OP_W    = 3;
  localparam int PORT_POS_W   = 7;
  localparam int PORT_DATA_W  = 32;
  localparam int PORT_COUNT_W = 7;

  // Wide enough for any position or count up to the largest supported capacity.
  localparam int POS_W = 11;

  // Number of cell hit words folded together in the first read reduction stage.
  localparam int GROUP_SIZE = 32;

  typedef enum logic [PORT_OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } iol_op_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             rd;
    logic [POS_W-1:0] pos;
  } iol_ctl_t;

endpackage

@@ rtl/core/indexed_ordered_list_unit.sv @@
// Top level of the indexed ordered list unit: control, cell row and result pipeline.
//
// The list is a row of CAPACITY cells; an insert or remove shifts every
// affected cell in the same clock, so the unit takes one request beat per
// cycle while the response side keeps up. After its request, each response
// beat passes the register for the cell row update and hit capture, the one
// for the grouped OR over the cell hit words, and the output register. A
// stalled response holds the whole result pipeline and with it the request
// side. Cell contents are not cleared at reset; only the count is.
module indexed_ordered_list_unit #(
  parameter int CAPACITY   = iol_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = iol_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [iol_pkg::PORT_OP_W-1:0]    operation,
  input  logic [iol_pkg::PORT_POS_W-1:0]   position,
  input  logic [iol_pkg::PORT_DATA_W-1:0]  data_in,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic                             ok,
  output logic [iol_pkg::PORT_DATA_W-1:0]  data_out,
  output logic [iol_pkg::PORT_COUNT_W-1:0] count
);
  import iol_pkg::*;

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int WideW = (DATA_WIDTH > PORT_DATA_W) ? DATA_WIDTH : PORT_DATA_W;

  logic                    adv;
  logic                    accept;
  logic [CntW-1:0]         held;
  logic [CntW-1:0]         held_next;
  logic [POS_W-1:0]        held_x;
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        cnt_x;
  logic                    not_full;
  logic                    ok_next;
  iol_ctl_t                ctl;
  logic [WideW-1:0]        wide_in;
  logic [DATA_WIDTH-1:0]   word_in;
  logic [DATA_WIDTH-1:0]   cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0]   cell_hit  [CAPACITY];
  logic [DATA_WIDTH-1:0]   red_word;
  logic [WideW-1:0]        red_wide;

  logic                    s1_v;
  logic                    s1_ok;
  logic [PORT_COUNT_W-1:0] s1_cnt;
  logic                    s2_v;
  logic                    s2_ok;
  logic [PORT_COUNT_W-1:0] s2_cnt;

  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;
  assign accept    = req_valid && adv;

  assign held_x   = POS_W'(held);
  assign pos_x    = POS_W'(position);
  assign not_full = held_x < POS_W'(CAPACITY);

  assign wide_in = WideW'(data_in);
  assign word_in = wide_in[DATA_WIDTH-1:0];

  // Append is an insert at the tail; only accepted, successful beats reach the cells.
  always_comb begin
    ctl       = '0;
    ok_next   = 1'b0;
    held_next = held;
    unique case (iol_op_t'(operation))
      OP_APPEND: begin
        if (not_full) begin
          ok_next   = 1'b1;
          ctl.ins   = accept;
          ctl.pos   = held_x;
          held_next = held + CntW'(1);
        end
      end
      OP_INSERT: begin
        if (not_full && (pos_x <= held_x)) begin
          ok_next   = 1'b1;
          ctl.ins   = accept;
          ctl.pos   = pos_x;
          held_next = held + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x < held_x) begin
          ok_next   = 1'b1;
          ctl.rem   = accept;
          ctl.rd    = accept;
          ctl.pos   = pos_x;
          held_next = held - CntW'(1);
        end
      end
      OP_READ: begin
        if (pos_x < held_x) begin
          ok_next = 1'b1;
          ctl.rd  = accept;
          ctl.pos = pos_x;
        end
      end
      OP_CLEAR: begin
        ok_next   = 1'b1;
        held_next = '0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  assign cnt_x = POS_W'(held_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_head
      assign left_w = word_in;
    end else begin : g_body
      assign left_w = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_word[i+1];
    end

    iol_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .adv        (adv),
      .ctl        (ctl),
      .load_word  (word_in),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .hit        (cell_hit[i])
    );
  end

  iol_reduce #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_reduce (
    .clk  (clk),
    .adv  (adv),
    .hit  (cell_hit),
    .word (red_word)
  );

  assign red_wide = WideW'(red_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= accept;
      s2_v      <= s1_v;
      rsp_valid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ok    <= ok_next;
      s1_cnt   <= cnt_x[PORT_COUNT_W-1:0];
      s2_ok    <= s1_ok;
      s2_cnt   <= s1_cnt;
      ok       <= s2_ok;
      count    <= s2_cnt;
      data_out <= red_wide[PORT_DATA_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_held_bound : assert property (@(posedge clk) disable iff (rst)
    held <= CntW'(CAPACITY))
    else $error("list count exceeds capacity");

  a_fail_no_data : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !ok |-> data_out == '0)
    else $error("failed response beat carries data");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_CLEAR) |=> held == '0)
    else $error("clear did not empty the list");

  a_full_append_holds : assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_APPEND) && (held == CntW'(CAPACITY)) |=> $stable(held))
    else $error("append into a full list changed the count");

  a_stall_holds_pipe : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> req_stall)
    else $error("request taken while the response is stalled");
`endif

endmodule

@@ rtl/core/iol_cell.sv @@
// One storage cell of the list row: holds a word and shifts with its neighbors.
module iol_cell #(
  parameter int DATA_WIDTH = iol_pkg::DEF_DATA_WIDTH,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  adv,
  input  iol_pkg::iol_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0] load_word,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] hit
);
  import iol_pkg::*;

  localparam logic [POS_W-1:0] Idx = POS_W'(INDEX);

  // On insert the cells past the position take the word from the head side;
  // on remove the cells at and past the position take it from the tail side.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (Idx == ctl.pos) begin
        word <= load_word;
      end else if (Idx > ctl.pos) begin
        word <= left_word;
      end
    end else if (ctl.rem) begin
      if (Idx >= ctl.pos) begin
        word <= right_word;
      end
    end
    if (adv) begin
      hit <= (ctl.rd && (Idx == ctl.pos)) ? word : '0;
    end
  end

endmodule

@@ rtl/core/iol_reduce.sv @@
// Registered OR tree that gathers the one nonzero hit word of the cell row.
module iol_reduce #(
  parameter int CAPACITY   = iol_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = iol_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [DATA_WIDTH-1:0] hit [CAPACITY],
  output logic [DATA_WIDTH-1:0] word
);
  import iol_pkg::*;

  localparam int NumGroups = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [DATA_WIDTH-1:0] group_next [NumGroups];
  logic [DATA_WIDTH-1:0] group      [NumGroups];

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      group_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          group_next[g] = group_next[g] | hit[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      group <= group_next;
    end
  end

  always_comb begin
    word = '0;
    for (int g = 0; g < NumGroups; g++) begin
      word = word | group[g];
    end
  end

endmodule

@@ test/tb_indexed_ordered_list_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the indexed ordered list unit with a built-in list predictor.
module tb_indexed_ordered_list_unit;
  import iol_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 150;

  localparam logic [PORT_OP_W-1:0]   OP_FIRST_UNUSED = 3'd5;
  localparam logic [PORT_OP_W-1:0]   OP_LAST_UNUSED  = 3'd7;
  localparam logic [PORT_POS_W-1:0]  POS_MAX         = '1;
  localparam logic [PORT_DATA_W-1:0] WORD_ONES       = '1;

  typedef struct packed {
    logic                    ok;
    logic [PORT_DATA_W-1:0]  word;
    logic [PORT_COUNT_W-1:0] count;
  } list_result_t;

  typedef enum int {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} walk_bias_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                    clk;
  logic                    rst;
  logic                    req_valid;
  logic                    req_stall;
  logic [PORT_OP_W-1:0]    operation;
  logic [PORT_POS_W-1:0]   position;
  logic [PORT_DATA_W-1:0]  data_in;
  logic                    rsp_valid;
  logic                    rsp_stall;
  logic                    ok;
  logic [PORT_DATA_W-1:0]  data_out;
  logic [PORT_COUNT_W-1:0] count;

  // Predictor state: a plain copy of the list and its length.
  logic [PORT_DATA_W-1:0] model_words [CAPACITY];
  int                     model_held = 0;
  list_result_t           pending_results [$];

  int errors         = 0;
  int quiet_cycles   = 0;
  int burst_left     = 0;
  bit sender_gaps_on = 1'b1;
  bit hold_request   = 1'b0;
  int beats_sent     = 0;
  int results_seen   = 0;
  int failed_ops     = 0;
  int peak_held      = 0;
  int long_holds     = 0;
  int op_seen [8];

  indexed_ordered_list_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .position  (position),
    .data_in   (data_in),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ok        (ok),
    .data_out  (data_out),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic list_result_t predict_list_op(input logic [PORT_OP_W-1:0] op,
                                                   input logic [PORT_POS_W-1:0] pos,
                                                   input logic [PORT_DATA_W-1:0] word);
    list_result_t res;
    int           p;
    int           i;
    res = '0;
    p = int'(pos);
    case (op)
      OP_APPEND: begin
        if (model_held < CAPACITY) begin
          model_words[model_held] = word;
          model_held++;
          res.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (p <= model_held && model_held < CAPACITY) begin
          for (i = model_held; i > p; i--) model_words[i] = model_words[i-1];
          model_words[p] = word;
          model_held++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (p < model_held) begin
          res.word = model_words[p];
          for (i = p; i + 1 < model_held; i++) model_words[i] = model_words[i+1];
          model_held--;
          res.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (p < model_held) begin
          res.word = model_words[p];
          res.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        model_held = 0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.count = PORT_COUNT_W'(model_held);
    return res;
  endfunction

  // Sends one request beat; when a burst runs out it may first insert a random gap.
  task automatic send_item(input logic [PORT_OP_W-1:0] op, input logic [PORT_POS_W-1:0] pos,
                           input logic [PORT_DATA_W-1:0] word);
    list_result_t res;
    int           gap;
    if (burst_left == 0) begin
      gap = 0;
      if (sender_gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        req_valid = 1'b0;
        operation = PORT_OP_W'($urandom);
        position  = PORT_POS_W'($urandom);
        data_in   = $urandom;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    req_valid = 1'b1;
    operation = op;
    position  = pos;
    data_in   = word;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    res = predict_list_op(op, pos, word);
    pending_results.push_back(res);
    beats_sent++;
    op_seen[op]++;
    if (!res.ok) failed_ops++;
    if (model_held > peak_held) peak_held = model_held;
  endtask

  task automatic send_random_item(input walk_bias_t bias);
    int                     roll;
    int                     w_app;
    int                     w_ins;
    int                     w_rem;
    logic [PORT_OP_W-1:0]   op;
    logic [PORT_POS_W-1:0]  pos;
    logic [PORT_DATA_W-1:0] word;
    case (bias)
      BIAS_GROW:   begin w_app = 30; w_ins = 35; w_rem = 10; end
      BIAS_SHRINK: begin w_app = 5;  w_ins = 10; w_rem = 50; end
      default:     begin w_app = 15; w_ins = 20; w_rem = 30; end
    endcase
    roll = $urandom_range(0, 499);
    if (roll == 0) begin
      op = OP_CLEAR;
    end else if (roll < 15) begin
      op = PORT_OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < w_app) op = OP_APPEND;
      else if (roll < w_app + w_ins) op = OP_INSERT;
      else if (roll < w_app + w_ins + w_rem) op = OP_REMOVE;
      else op = OP_READ;
    end
    // Mostly legal positions so the list gets deep; one in ten is anywhere in the field.
    if ($urandom_range(0, 9) == 0 || !(op == OP_INSERT || op == OP_REMOVE || op == OP_READ))
      pos = PORT_POS_W'($urandom);
    else if (op == OP_INSERT)
      pos = PORT_POS_W'($urandom_range(0, model_held));
    else
      pos = (model_held > 0) ? PORT_POS_W'($urandom_range(0, model_held - 1)) : '0;
    case ($urandom_range(0, 15))
      0:       word = '0;
      1:       word = WORD_ONES;
      default: word = $urandom;
    endcase
    send_item(op, pos, word);
  endtask

  task automatic test_directed_edges();
    send_item(OP_READ,   '0, $urandom);
    send_item(OP_REMOVE, '0, $urandom);
    send_item(OP_INSERT, PORT_POS_W'(1), $urandom);
    send_item(OP_INSERT, '0, WORD_ONES);
    send_item(OP_APPEND, POS_MAX, '0);
    send_item(OP_INSERT, PORT_POS_W'(2), 32'hA5A5_A5A5);
    send_item(OP_INSERT, PORT_POS_W'(1), 32'h5A5A_5A5A);
    send_item(OP_READ,   PORT_POS_W'(0), $urandom);
    send_item(OP_READ,   PORT_POS_W'(1), $urandom);
    send_item(OP_READ,   PORT_POS_W'(2), $urandom);
    send_item(OP_READ,   PORT_POS_W'(3), $urandom);
    send_item(OP_READ,   PORT_POS_W'(4), $urandom);
    send_item(OP_READ,   PORT_POS_W'(CAPACITY), $urandom);
    send_item(OP_REMOVE, POS_MAX, $urandom);
    send_item(OP_REMOVE, PORT_POS_W'(3), $urandom);
    send_item(OP_REMOVE, '0, $urandom);
    send_item(OP_FIRST_UNUSED, '0, WORD_ONES);
    send_item(OP_FIRST_UNUSED + 3'd1, '0, WORD_ONES);
    send_item(OP_LAST_UNUSED, POS_MAX, WORD_ONES);
    send_item(OP_CLEAR, PORT_POS_W'(99), WORD_ONES);
    send_item(OP_READ,  '0, $urandom);
  endtask

  task automatic test_fill_to_capacity();
    int n;
    for (n = 0; n < CAPACITY; n++) send_item(OP_APPEND, PORT_POS_W'($urandom), $urandom);
    send_item(OP_APPEND, '0, $urandom);
    send_item(OP_INSERT, '0, $urandom);
    send_item(OP_INSERT, PORT_POS_W'(CAPACITY), $urandom);
    send_item(OP_READ,   PORT_POS_W'(CAPACITY - 1), $urandom);
    send_item(OP_READ,   PORT_POS_W'(CAPACITY), $urandom);
    send_item(OP_REMOVE, '0, $urandom);
    send_item(OP_INSERT, PORT_POS_W'(CAPACITY - 1), $urandom);
    send_item(OP_REMOVE, PORT_POS_W'(CAPACITY - 1), $urandom);
    send_item(OP_READ,   POS_MAX, $urandom);
  endtask

  // The receiver holds off for a long stretch while beats keep coming back to back.
  task automatic test_output_backpressure();
    int n;
    sender_gaps_on = 1'b0;
    hold_request = 1'b1;
    for (n = 0; n < 60; n++) send_random_item(BIAS_MIXED);
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_walk(input int n_items);
    walk_bias_t bias;
    int         phase_left;
    int         n;
    phase_left = 0;
    bias = BIAS_GROW;
    for (n = 0; n < n_items; n++) begin
      if (phase_left == 0) begin
        bias = walk_bias_t'($urandom_range(0, 2));
        phase_left = $urandom_range(50, 250);
      end
      phase_left--;
      send_random_item(bias);
    end
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int          window;
    int          period;
    int          hold;
    rsp_stall = 1'b0;
    mode = STALL_NONE;
    window = 0;
    period = 2;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LONG_HOLD;
        long_holds++;
      end
      if (window == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        window = $urandom_range(20, 200);
        period = $urandom_range(2, 6);
      end
      window--;
      if (hold > 0) begin
        hold--;
        rsp_stall = 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  rsp_stall = 1'b0;
          STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: rsp_stall = ($urandom_range(0, 9) < 7);
          default:     rsp_stall = (window % period == 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [PORT_DATA_W-1:0] want,
                                      input logic [PORT_DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_checker
    list_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual ok=%b data_out=%h count=%0d",
                 $time, ok, data_out, count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, ok);
        check_field("data_out", want.word, data_out);
        check_field("count", want.count, count);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : main
    rst = 1'b1;
    req_valid = 1'b0;
    operation = '0;
    position = '0;
    data_in = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_edges();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_walk(1100);
    @(negedge clk);
    req_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d request beats and %0d checked results, %0d of them failed ops,",
             beats_sent, results_seen, failed_ops);
    $display("peak length %0d of %0d; append %0d insert %0d remove %0d read %0d clear %0d unused %0d.",
             peak_held, CAPACITY, op_seen[OP_APPEND], op_seen[OP_INSERT], op_seen[OP_REMOVE],
             op_seen[OP_READ], op_seen[OP_CLEAR],
             op_seen[OP_FIRST_UNUSED] + op_seen[OP_FIRST_UNUSED + 3'd1] +
             op_seen[OP_LAST_UNUSED]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
